FILE: rtl/efba_pkg.sv
// ----------------------------------------------------------------------------
// efba_pkg
// Types, codes and sizes shared by the extent free-list block allocator.
// ----------------------------------------------------------------------------
package efba_pkg;

  localparam int MAX_BLOCKS = 4096;

  localparam int BLK_W  = 12;
  localparam int VS_W   = 13;
  localparam int FUNC_W = 2;
  localparam int REC_W  = 2 * BLK_W;

  // Record storage never needs more entries than a 12-bit block number can reach.
  localparam int MEM_DEPTH = (MAX_BLOCKS < (1 << BLK_W)) ? MAX_BLOCKS : (1 << BLK_W);
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [VS_W-1:0]  VS_RESET  = VS_W'(4096);
  localparam logic [VS_W-1:0]  VS_MIN    = VS_W'(2);
  localparam logic [VS_W-1:0]  VS_CAP    = VS_W'(MEM_DEPTH);
  localparam logic [BLK_W-1:0] COUNT_MAX = {BLK_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FN_FORMAT = 2'd0,
    FN_ALLOC  = 2'd1,
    FN_FREE   = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef struct packed {
    logic accept;  // capture the request and read the head record
    logic exec;    // apply the operation and load the result register
  } efba_cmd_t;

endpackage

FILE: rtl/efba_in_if.sv
// ----------------------------------------------------------------------------
// efba_in_if
// Request channel: operation code and block number with valid/ready.
// ----------------------------------------------------------------------------
interface efba_in_if;
  import efba_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BLK_W-1:0]  block_index;

  modport source (output valid, output func, output block_index, input ready);
  modport sink   (input valid, input func, input block_index, output ready);

endinterface

FILE: rtl/efba_out_if.sv
// ----------------------------------------------------------------------------
// efba_out_if
// Result channel: allocated block, full flag and free count with valid/ready.
// ----------------------------------------------------------------------------
interface efba_out_if;
  import efba_pkg::*;

  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] allocated_block;
  logic             volume_full;
  logic [BLK_W-1:0] free_blocks;

  modport source (output valid, output allocated_block, output volume_full,
                  output free_blocks, input ready);
  modport sink   (input valid, input allocated_block, input volume_full,
                  input free_blocks, output ready);

endinterface

FILE: rtl/efba_ctrl.sv
// ----------------------------------------------------------------------------
// efba_ctrl
// Sequencer: takes one request, waits for the result register to free up,
// then has the datapath execute it.
// ----------------------------------------------------------------------------
module efba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output efba_pkg::efba_cmd_t cmd
);
  import efba_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.accept    = in_ready_r && in_valid;
    cmd.exec      = (state_r == S_EXEC) && (!out_valid_r || out_ready);
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt    = S_EXEC;
          in_ready_nxt = 1'b0;
        end
      end
      S_EXEC: begin
        if (cmd.exec) begin
          state_nxt     = S_IDLE;
          in_ready_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/efba_datapath.sv
// ----------------------------------------------------------------------------
// efba_datapath
// Head pointer, free count, volume size register, extent record memory and
// result register.
// ----------------------------------------------------------------------------
module efba_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  efba_pkg::efba_cmd_t      cmd,
  input  logic                     cfg_we,
  input  logic [efba_pkg::VS_W-1:0]   cfg_wdata,
  input  logic [efba_pkg::FUNC_W-1:0] in_func,
  input  logic [efba_pkg::BLK_W-1:0]  in_block_index,
  output logic [efba_pkg::BLK_W-1:0]  out_allocated_block,
  output logic                        out_volume_full,
  output logic [efba_pkg::BLK_W-1:0]  out_free_blocks
);
  import efba_pkg::*;

  logic [REC_W-1:0] mem [MEM_DEPTH];

  logic [BLK_W-1:0] head_r, head_nxt;
  logic [BLK_W-1:0] count_r, count_nxt;
  logic [VS_W-1:0]  vol_r;
  func_t            op_r;
  logic [BLK_W-1:0] idx_r;
  logic [REC_W-1:0] rd_data_r;
  logic             rd_ok_r;
  logic [BLK_W-1:0] alloc_r, alloc_nxt;
  logic             full_r, full_nxt;
  logic [BLK_W-1:0] free_r;

  logic             mem_we;
  logic [BLK_W-1:0] mem_waddr;
  logic [REC_W-1:0] mem_wdata;
  logic [VS_W-1:0]  vs_sat;
  logic [VS_W-1:0]  vs_m1;
  logic [BLK_W-1:0] run;
  logic [BLK_W-1:0] next_blk;
  logic [BLK_W-1:0] head_inc;

  always_comb begin
    if (vol_r < VS_MIN) begin
      vs_sat = VS_MIN;
    end else if (vol_r > VS_CAP) begin
      vs_sat = VS_CAP;
    end else begin
      vs_sat = vol_r;
    end
    vs_m1 = vs_sat - VS_W'(1);

    // A record outside the store reads as an empty extent.
    run      = rd_ok_r ? rd_data_r[BLK_W-1:0] : '0;
    next_blk = rd_ok_r ? rd_data_r[REC_W-1:BLK_W] : '0;
    head_inc = head_r + BLK_W'(1);

    head_nxt  = head_r;
    count_nxt = count_r;
    alloc_nxt = '0;
    full_nxt  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = head_inc;
    mem_wdata = {next_blk, run - BLK_W'(1)};

    case (op_r)
      FN_FORMAT: begin
        head_nxt  = BLK_W'(1);
        count_nxt = vs_m1[BLK_W-1:0];
        mem_we    = 1'b1;
        mem_waddr = BLK_W'(1);
        mem_wdata = {{BLK_W{1'b0}}, vs_m1[BLK_W-1:0]};
      end
      FN_ALLOC: begin
        if (count_r == '0) begin
          full_nxt = 1'b1;
        end else begin
          alloc_nxt = head_r;
          count_nxt = count_r - BLK_W'(1);
          // A run longer than one block moves its record up by one block.
          if (run > BLK_W'(1)) begin
            head_nxt = head_inc;
            mem_we   = 1'b1;
          end else begin
            head_nxt = next_blk;
          end
        end
      end
      FN_FREE: begin
        head_nxt  = idx_r;
        count_nxt = (count_r != COUNT_MAX) ? count_r + BLK_W'(1) : count_r;
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = {head_r, BLK_W'(1)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= BLK_W'(1);
      count_r <= '0;
      vol_r   <= VS_RESET;
    end else begin
      if (cfg_we) begin
        vol_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= func_t'(in_func);
      idx_r <= in_block_index;
    end
    if (cmd.exec) begin
      alloc_r <= alloc_nxt;
      full_r  <= full_nxt;
      free_r  <= count_nxt;
    end
  end

  // The head record is read when the request is taken; the head cannot move
  // before the request executes.
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we && ({1'b0, mem_waddr} < VS_CAP)) begin
      mem[mem_waddr[MEM_AW-1:0]] <= mem_wdata;
    end
    if (cmd.accept) begin
      rd_data_r <= mem[head_r[MEM_AW-1:0]];
      rd_ok_r   <= ({1'b0, head_r} < VS_CAP);
    end
  end

  assign out_allocated_block = alloc_r;
  assign out_volume_full     = full_r;
  assign out_free_blocks     = free_r;

endmodule

FILE: rtl/extent_free_list_block_allocator.sv
// ----------------------------------------------------------------------------
// extent_free_list_block_allocator
// Block allocator whose free space is a linked list of extent records.
// ----------------------------------------------------------------------------
// A request is taken in its transfer cycle, when the head extent record is
// read from the single-port synchronous record memory, and then executes: it
// updates the head pointer and free count, writes a record back if needed
// and loads the result register. A request may be taken while the last
// result still waits; it then holds in the execute state until that result
// is transferred, and no new request is taken until it executes. The record
// memory is not cleared at reset; format must run before allocate is used.
module extent_free_list_block_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  efba_in_if.sink                   in_ch,
  efba_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [efba_pkg::VS_W-1:0] cfg_wdata
);
  import efba_pkg::*;

  efba_cmd_t cmd;

  efba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  efba_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_func             (in_ch.func),
    .in_block_index      (in_ch.block_index),
    .out_allocated_block (out_ch.allocated_block),
    .out_volume_full     (out_ch.volume_full),
    .out_free_blocks     (out_ch.free_blocks)
  );

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while another was still executing");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result appeared without an executing request");

  a_full_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.volume_full) |->
      (out_ch.allocated_block == '0 && out_ch.free_blocks == '0))
    else $error("full volume reported with a block or a nonzero count");

endmodule
